@@ design/spq_pkg.sv @@
// Package with the beat types, entry layout and codes of the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned OCC_W = 5;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_EXTRACTED = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [15:0] entry_id;
    logic [7:0]  entry_age;
    logic [7:0]  entry_level;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      out_id;
    logic [7:0]       out_age;
    logic [7:0]       out_level;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [7:0]  level;
  } entry_t;

  // Broadcast to every cell in the cycle a request is applied.
  typedef struct packed {
    logic   do_insert;
    logic   do_extract;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

@@ design/spq_cell.sv @@
// One cell of the sorted chain: holds one entry and moves it to or from its neighbors.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      vld,
  input  logic      prev_ge,
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output logic      ge,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A held entry stays ahead of a new one of equal level, which keeps service stable.
  assign ge    = vld && (entry_r.level >= ctl.new_entry.level);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_extract) begin
      entry_nxt = next_entry;
    end else if (ctl.do_insert) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (prev_ge) begin
        entry_nxt = ctl.new_entry;
      end else begin
        entry_nxt = prev_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ design/stable_priority_queue_core.sv @@
// Top level of the stable priority queue: a sorted chain of entry cells and a result register.
`timescale 1ns / 1ps
// The queue keeps its entries in a chain of DEPTH cells sorted by level, highest first,
// and in arrival order within a level, so the head cell always holds the next entry to
// serve. For each accepted request beat, an insert opens a gap
// behind all entries of equal or higher level and the tail of the chain shifts down one
// cell, an extract takes the head and the whole chain shifts up one cell. The result beat
// appears in the output register on the cycle after acceptance, and a new request can be
// accepted every cycle; in_ready is low only while a result waits in the output register
// and out_ready is low. Inserting into a full queue and extracting from an empty one
// leave the contents unchanged and report that in the status field.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  rsp_t          rsp_r;
  rsp_t          rsp_nxt;

  logic      in_fire;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;

  logic   [DEPTH-1:0] cell_vld;
  logic   [DEPTH-1:0] cell_ge;
  entry_t             cell_entry [DEPTH];

  logic [CW+OCC_W-1:0] count_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    ctl.do_insert       = in_fire && (in_req.req_type == REQ_INSERT) && !is_full;
    ctl.do_extract      = in_fire && (in_req.req_type == REQ_EXTRACT) && !is_empty;
    ctl.new_entry.id    = in_req.entry_id;
    ctl.new_entry.age   = in_req.entry_age;
    ctl.new_entry.level = in_req.entry_level;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    entry_t next_entry;
    logic   prev_ge;

    assign cell_vld[i] = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = ctl.new_entry;
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .vld        (cell_vld[i]),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .ge         (cell_ge[i]),
      .entry      (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.do_extract) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_ext = (CW + OCC_W)'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    rsp_nxt       = rsp_r;
    if (in_fire) begin
      out_valid_nxt     = 1'b1;
      rsp_nxt.out_id    = '0;
      rsp_nxt.out_age   = '0;
      rsp_nxt.out_level = '0;
      rsp_nxt.occupancy = count_ext[OCC_W-1:0];
      if (in_req.req_type == REQ_INSERT) begin
        rsp_nxt.status = is_full ? ST_FULL : ST_INSERTED;
      end else if (is_empty) begin
        rsp_nxt.status = ST_EMPTY;
      end else begin
        rsp_nxt.status    = ST_EXTRACTED;
        rsp_nxt.out_id    = cell_entry[0].id;
        rsp_nxt.out_age   = cell_entry[0].age;
        rsp_nxt.out_level = cell_entry[0].level;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rsp_r <= rsp_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (cell_entry[0].level >= cell_entry[1].level))
    else $error("head cell not at highest level");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req.req_type == REQ_INSERT) && !is_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the queue");

  a_extract_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req.req_type == REQ_EXTRACT) && !is_empty)
      |=> (out_valid_r && (rsp_r.status == ST_EXTRACTED)
           && (rsp_r.out_level == $past(cell_entry[0].level))))
    else $error("extract did not return the head entry");
`endif

endmodule
